/* rtl/fsp_pkg.sv */
// Shared types, constants and character helpers for the format specifier parser.
package fsp_pkg;

    localparam int NUMBER_BITS_DEFAULT = 32;

    typedef enum logic [2:0] {
        ST_FLAGS   = 3'd0,
        ST_WSTART  = 3'd1,
        ST_WDIGITS = 3'd2,
        ST_DOT     = 3'd3,
        ST_PSTART  = 3'd4,
        ST_PDIGITS = 3'd5,
        ST_LENGTH  = 3'd6,
        ST_CONV    = 3'd7
    } stage_t;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_H    = 2'd1;
    localparam logic [1:0] LEN_L    = 2'd2;
    localparam logic [1:0] LEN_BIG_L = 2'd3;

    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;
    localparam logic [7:0] CH_UPPER_L = 8'h4C;

    localparam logic [31:0] OUT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] OUT_NEG_MAX = 32'h8000_0000;

    // One-hot flag position for minus, plus, space, hash and zero; zero when not a flag.
    function automatic logic [4:0] flag_mask(input logic [7:0] c);
        logic [4:0] m;
        begin
            m = 5'b00000;
            case (c)
                CH_MINUS: m = 5'b00001;
                CH_PLUS:  m = 5'b00010;
                CH_SPACE: m = 5'b00100;
                CH_HASH:  m = 5'b01000;
                CH_ZERO:  m = 5'b10000;
                default:  m = 5'b00000;
            endcase
            return m;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_conv_char(input logic [7:0] c);
        return c inside {CH_PERCENT, 8'h63, 8'h64, 8'h65, 8'h45, 8'h66, 8'h67, 8'h47,
                         8'h6F, 8'h73, 8'h75, 8'h78, 8'h58, 8'h70, 8'h6E, 8'h69};
    endfunction

endpackage

/* rtl/format_specifier_parser_unit.sv */
// Top level of the format specifier parser: stage registers, update logic and result register.
// A result is registered and appears on the output in the cycle after its terminating character is accepted.
// Throughput: one character per cycle; the whole stage walk, including fall-through, is done
// by the update logic in front of the stage registers within that cycle.
// The input stalls only while a result waits in the output register and the output stalls.
// Reset puts the parser in the flags stage with cleared fields and sets printf style.
module format_specifier_parser_unit
    import fsp_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_enable,
    input  logic               cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         format_char,
    input  logic signed [31:0] argument_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               flag_minus,
    output logic               flag_plus,
    output logic               flag_space,
    output logic               flag_alternate,
    output logic               flag_zero_pad,
    output logic               suppress_assign,
    output logic [30:0]        field_width,
    output logic signed [31:0] field_precision,
    output logic               precision_absent,
    output logic [1:0]         length_code,
    output logic [7:0]         conversion_char,
    output logic               last_consumed
);

    localparam int AW = NUMBER_BITS - 1;
    localparam int PW = (NUMBER_BITS - 1 > 32) ? NUMBER_BITS - 1 : 32;
    localparam logic [AW-1:0] NUM_MAX = {AW{1'b1}};

    logic          scan_mode_reg;
    stage_t        stage_reg, stage_next;
    logic [4:0]    flag_bits_reg, flag_bits_next;
    logic          suppress_reg, suppress_next;
    logic [AW-1:0] width_acc_reg, width_acc_next;
    logic [PW-1:0] prec_acc_reg, prec_acc_next;
    logic          prec_neg_reg, prec_neg_next;
    logic          prec_stop_reg, prec_stop_next;
    logic          no_dot_reg, no_dot_next;
    logic [1:0]    length_reg, length_next;

    logic          out_valid_reg, out_valid_next;
    logic [4:0]    out_flags_reg;
    logic          out_suppress_reg;
    logic [30:0]   out_width_reg;
    logic [31:0]   out_prec_reg;
    logic          out_absent_reg;
    logic [1:0]    out_length_reg;
    logic [7:0]    out_conv_reg;
    logic          out_consumed_reg;

    logic          accept;
    logic          consumed;
    logic          emit;
    logic          conv_ok;
    logic [4:0]    fmask;
    logic          arg_neg;
    logic [31:0]   arg_mag;
    logic [PW-1:0] arg_mag_ext;
    logic [3:0]    digit;
    logic [AW+3:0] width_sum;
    logic [AW+3:0] prec_sum;
    logic [AW-1:0] width_add;
    logic [AW-1:0] prec_add;
    logic [PW-1:0] width_ext;
    logic [30:0]   width_out;
    logic [31:0]   prec_mag;
    logic [31:0]   prec_out;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign fmask       = flag_mask(format_char);
    assign conv_ok     = is_conv_char(format_char);
    assign arg_neg     = argument_value[31];
    assign arg_mag     = arg_neg ? (32'd0 - 32'(argument_value)) : 32'(argument_value);
    assign arg_mag_ext = PW'(arg_mag);
    assign digit       = 4'(format_char - CH_ZERO);

    // Decimal accumulate as acc*8 + acc*2 + digit, saturating at the top of the range.
    assign width_sum = {1'b0, width_acc_reg, 3'b000} + {3'b000, width_acc_reg, 1'b0}
                       + (AW+4)'(digit);
    assign prec_sum  = {1'b0, prec_acc_reg[AW-1:0], 3'b000}
                       + {3'b000, prec_acc_reg[AW-1:0], 1'b0}
                       + (AW+4)'(digit);
    assign width_add = (width_sum > (AW+4)'(NUM_MAX)) ? NUM_MAX : width_sum[AW-1:0];
    assign prec_add  = (prec_sum > (AW+4)'(NUM_MAX)) ? NUM_MAX : prec_sum[AW-1:0];

    assign width_ext = PW'(width_acc_reg);
    assign width_out = (width_ext > PW'(OUT_POS_MAX)) ? OUT_POS_MAX[30:0] : width_ext[30:0];
    assign prec_mag  = prec_neg_reg
                       ? ((prec_acc_reg > PW'(OUT_NEG_MAX)) ? OUT_NEG_MAX : prec_acc_reg[31:0])
                       : ((prec_acc_reg > PW'(OUT_POS_MAX)) ? OUT_POS_MAX : prec_acc_reg[31:0]);
    assign prec_out  = prec_neg_reg ? (32'd0 - prec_mag) : prec_mag;

    always_comb
    begin
        stage_next     = stage_reg;
        flag_bits_next = flag_bits_reg;
        suppress_next  = suppress_reg;
        width_acc_next = width_acc_reg;
        prec_acc_next  = prec_acc_reg;
        prec_neg_next  = prec_neg_reg;
        prec_stop_next = prec_stop_reg;
        no_dot_next    = no_dot_reg;
        length_next    = length_reg;
        consumed       = 1'b0;
        emit           = 1'b0;

        if (stage_next == ST_FLAGS)
        begin
            if (fmask != 5'b00000)
            begin
                flag_bits_next = flag_bits_reg | fmask;
                consumed = 1'b1;
            end
            else
            begin
                stage_next = ST_WSTART;
            end
        end

        if (!consumed && stage_next == ST_WSTART)
        begin
            if (format_char == CH_STAR)
            begin
                if (scan_mode_reg)
                begin
                    suppress_next = 1'b1;
                end
                else
                begin
                    if (arg_neg)
                    begin
                        flag_bits_next = flag_bits_next | 5'b00001;
                    end
                    width_acc_next = (arg_mag_ext > PW'(NUM_MAX)) ? NUM_MAX
                                                                 : arg_mag_ext[AW-1:0];
                end
                stage_next = ST_DOT;
                consumed = 1'b1;
            end
            else
            begin
                stage_next = ST_WDIGITS;
            end
        end

        if (!consumed && stage_next == ST_WDIGITS)
        begin
            if (is_digit(format_char))
            begin
                width_acc_next = width_add;
                consumed = 1'b1;
            end
            else
            begin
                stage_next = ST_DOT;
            end
        end

        if (!consumed && stage_next == ST_DOT)
        begin
            if (format_char == CH_DOT)
            begin
                stage_next = ST_PSTART;
                consumed = 1'b1;
            end
            else
            begin
                no_dot_next = 1'b1;
                stage_next = ST_LENGTH;
            end
        end

        if (!consumed && stage_next == ST_PSTART)
        begin
            if (format_char == CH_STAR)
            begin
                prec_neg_next = arg_neg;
                prec_acc_next = arg_mag_ext;
                stage_next = ST_LENGTH;
                consumed = 1'b1;
            end
            else if (format_char == CH_MINUS)
            begin
                prec_neg_next = 1'b1;
                stage_next = ST_PDIGITS;
                consumed = 1'b1;
            end
            else if (is_digit(format_char))
            begin
                prec_acc_next = PW'(prec_add);
                stage_next = ST_PDIGITS;
                consumed = 1'b1;
            end
            else
            begin
                stage_next = ST_LENGTH;
            end
        end

        if (!consumed && stage_next == ST_PDIGITS)
        begin
            if (format_char == CH_MINUS)
            begin
                prec_stop_next = 1'b1;
                consumed = 1'b1;
            end
            else if (is_digit(format_char))
            begin
                if (!prec_stop_reg)
                begin
                    prec_acc_next = PW'(prec_add);
                end
                consumed = 1'b1;
            end
            else
            begin
                stage_next = ST_LENGTH;
            end
        end

        if (!consumed && stage_next == ST_LENGTH)
        begin
            stage_next = ST_CONV;
            if (format_char == CH_LOWER_H)
            begin
                length_next = LEN_H;
                consumed = 1'b1;
            end
            else if (format_char == CH_LOWER_L)
            begin
                length_next = LEN_L;
                consumed = 1'b1;
            end
            else if (format_char == CH_UPPER_L)
            begin
                length_next = LEN_BIG_L;
                consumed = 1'b1;
            end
        end

        if (!consumed && stage_next == ST_CONV)
        begin
            emit           = 1'b1;
            stage_next     = ST_FLAGS;
            flag_bits_next = 5'b00000;
            suppress_next  = 1'b0;
            width_acc_next = '0;
            prec_acc_next  = '0;
            prec_neg_next  = 1'b0;
            prec_stop_next = 1'b0;
            no_dot_next    = 1'b0;
            length_next    = LEN_NONE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg <= 1'b0;
            stage_reg     <= ST_FLAGS;
            flag_bits_reg <= 5'b00000;
            suppress_reg  <= 1'b0;
            width_acc_reg <= '0;
            prec_acc_reg  <= '0;
            prec_neg_reg  <= 1'b0;
            prec_stop_reg <= 1'b0;
            no_dot_reg    <= 1'b0;
            length_reg    <= LEN_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                scan_mode_reg <= cfg_write_data;
            end
            if (accept)
            begin
                stage_reg     <= stage_next;
                flag_bits_reg <= flag_bits_next;
                suppress_reg  <= suppress_next;
                width_acc_reg <= width_acc_next;
                prec_acc_reg  <= prec_acc_next;
                prec_neg_reg  <= prec_neg_next;
                prec_stop_reg <= prec_stop_next;
                no_dot_reg    <= no_dot_next;
                length_reg    <= length_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_flags_reg    <= flag_bits_reg;
            out_suppress_reg <= suppress_reg;
            out_width_reg    <= width_out;
            out_prec_reg     <= prec_out;
            out_absent_reg   <= no_dot_reg || (stage_reg <= ST_DOT);
            out_length_reg   <= length_reg;
            out_conv_reg     <= conv_ok ? format_char : 8'h00;
            out_consumed_reg <= conv_ok;
        end
    end

    assign out_valid        = out_valid_reg;
    assign flag_minus       = out_flags_reg[0];
    assign flag_plus        = out_flags_reg[1];
    assign flag_space       = out_flags_reg[2];
    assign flag_alternate   = out_flags_reg[3];
    assign flag_zero_pad    = out_flags_reg[4];
    assign suppress_assign  = out_suppress_reg;
    assign field_width      = out_width_reg;
    assign field_precision  = out_prec_reg;
    assign precision_absent = out_absent_reg;
    assign length_code      = out_length_reg;
    assign conversion_char  = out_conv_reg;
    assign last_consumed    = out_consumed_reg;

endmodule

/* tb/format_specifier_parser_unit_test.sv */
// Self-checking testbench for format_specifier_parser_unit with its own specifier parsing model.
`timescale 1ns / 1ps

module format_specifier_parser_unit_test
    import fsp_pkg::*;
();

    typedef struct packed {
        logic [7:0]  ch;
        logic [31:0] arg;
    } char_req_t;

    typedef struct packed {
        logic        minus;
        logic        plus;
        logic        space;
        logic        alternate;
        logic        zero_pad;
        logic        suppress;
        logic [30:0] width;
        logic [31:0] precision;
        logic        no_precision;
        logic [1:0]  length;
        logic [7:0]  conversion;
        logic        consumed;
    } spec_result_t;

    localparam logic [63:0] NUM_LIMIT = (64'd1 << (NUMBER_BITS_DEFAULT - 1)) - 64'd1;
    localparam logic [39:0] FLAG_SET = {CH_ZERO, CH_HASH, CH_SPACE, CH_PLUS, CH_MINUS};
    localparam logic [119:0] CONV_LETTERS = "cdeEfgGosuxXpni";

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write_enable = 1'b0;
    logic               cfg_write_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         format_char = 8'h00;
    logic signed [31:0] argument_value = 32'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               flag_minus;
    logic               flag_plus;
    logic               flag_space;
    logic               flag_alternate;
    logic               flag_zero_pad;
    logic               suppress_assign;
    logic [30:0]        field_width;
    logic signed [31:0] field_precision;
    logic               precision_absent;
    logic [1:0]         length_code;
    logic [7:0]         conversion_char;
    logic               last_consumed;

    char_req_t    pending_chars[$];
    spec_result_t expected_specs[$];
    spec_result_t parsed_spec;
    spec_result_t oldest_spec;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned chars_queued = 0;
    int unsigned chars_accepted = 0;
    int unsigned specs_checked = 0;
    int unsigned mismatches = 0;

    logic        scan_setting = 1'b0;
    stage_t      spec_stage = ST_FLAGS;
    logic [4:0]  spec_flags = 5'b0;
    logic        spec_suppress = 1'b0;
    logic [63:0] width_acc = 64'd0;
    logic [63:0] prec_acc = 64'd0;
    logic        prec_neg = 1'b0;
    logic        prec_frozen = 1'b0;
    logic        dot_missing = 1'b0;
    logic [1:0]  length_sel = LEN_NONE;

    format_specifier_parser_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .format_char      (format_char),
        .argument_value   (argument_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .flag_minus       (flag_minus),
        .flag_plus        (flag_plus),
        .flag_space       (flag_space),
        .flag_alternate   (flag_alternate),
        .flag_zero_pad    (flag_zero_pad),
        .suppress_assign  (suppress_assign),
        .field_width      (field_width),
        .field_precision  (field_precision),
        .precision_absent (precision_absent),
        .length_code      (length_code),
        .conversion_char  (conversion_char),
        .last_consumed    (last_consumed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [7:0] c);
        logic [63:0] d;
        begin
            d = {56'd0, c - CH_ZERO};
            if (acc > (NUM_LIMIT - d) / 64'd10)
                return NUM_LIMIT;
            return acc * 64'd10 + d;
        end
    endfunction

    // Advances the specifier state by one character; returns 1 when a specifier completes.
    function automatic logic parse_spec_char(input logic [7:0] c, input logic [31:0] arg,
                                             output spec_result_t res);
        logic [63:0] arg_mag;
        logic [63:0] m;
        logic        arg_neg;
        logic        settled;
        logic        emitted;
        logic        conv_ok;
        int          k;
        begin
            arg_neg = arg[31];
            arg_mag = arg_neg ? (64'h1_0000_0000 - {32'd0, arg}) : {32'd0, arg};
            res = '0;
            settled = 1'b0;
            emitted = 1'b0;
            while (!settled)
            begin
                case (spec_stage)
                    ST_FLAGS:
                    begin
                        k = -1;
                        for (int i = 0; i < 5; i++)
                            if (c != 8'h00 && c == FLAG_SET[i*8 +: 8])
                                k = i;
                        if (k >= 0)
                        begin
                            spec_flags[k] = 1'b1;
                            settled = 1'b1;
                        end
                        else
                            spec_stage = ST_WSTART;
                    end
                    ST_WSTART:
                    begin
                        if (c == CH_STAR)
                        begin
                            if (scan_setting)
                                spec_suppress = 1'b1;
                            else
                            begin
                                if (arg_neg)
                                    spec_flags[0] = 1'b1;
                                width_acc = (arg_mag > NUM_LIMIT) ? NUM_LIMIT : arg_mag;
                            end
                            spec_stage = ST_DOT;
                            settled = 1'b1;
                        end
                        else
                            spec_stage = ST_WDIGITS;
                    end
                    ST_WDIGITS:
                    begin
                        if (digit_char(c))
                        begin
                            width_acc = add_digit(width_acc, c);
                            settled = 1'b1;
                        end
                        else
                            spec_stage = ST_DOT;
                    end
                    ST_DOT:
                    begin
                        if (c == CH_DOT)
                        begin
                            spec_stage = ST_PSTART;
                            settled = 1'b1;
                        end
                        else
                        begin
                            dot_missing = 1'b1;
                            spec_stage = ST_LENGTH;
                        end
                    end
                    ST_PSTART:
                    begin
                        if (c == CH_STAR)
                        begin
                            prec_neg = arg_neg;
                            prec_acc = arg_mag;
                            spec_stage = ST_LENGTH;
                            settled = 1'b1;
                        end
                        else if (c == CH_MINUS)
                        begin
                            prec_neg = 1'b1;
                            spec_stage = ST_PDIGITS;
                            settled = 1'b1;
                        end
                        else if (digit_char(c))
                        begin
                            prec_acc = add_digit(prec_acc, c);
                            spec_stage = ST_PDIGITS;
                            settled = 1'b1;
                        end
                        else
                            spec_stage = ST_LENGTH;
                    end
                    ST_PDIGITS:
                    begin
                        if (c == CH_MINUS)
                        begin
                            prec_frozen = 1'b1;
                            settled = 1'b1;
                        end
                        else if (digit_char(c))
                        begin
                            if (!prec_frozen)
                                prec_acc = add_digit(prec_acc, c);
                            settled = 1'b1;
                        end
                        else
                            spec_stage = ST_LENGTH;
                    end
                    ST_LENGTH:
                    begin
                        spec_stage = ST_CONV;
                        if (c == CH_LOWER_H || c == CH_LOWER_L || c == CH_UPPER_L)
                        begin
                            length_sel = (c == CH_LOWER_H) ? LEN_H :
                                         (c == CH_LOWER_L) ? LEN_L : LEN_BIG_L;
                            settled = 1'b1;
                        end
                    end
                    default:
                    begin
                        conv_ok = (c == CH_PERCENT);
                        for (int i = 0; i < 15; i++)
                            if (c == CONV_LETTERS[i*8 +: 8])
                                conv_ok = 1'b1;
                        res.minus = spec_flags[0];
                        res.plus = spec_flags[1];
                        res.space = spec_flags[2];
                        res.alternate = spec_flags[3];
                        res.zero_pad = spec_flags[4];
                        res.suppress = spec_suppress;
                        m = (width_acc > {32'd0, OUT_POS_MAX}) ? {32'd0, OUT_POS_MAX} : width_acc;
                        res.width = m[30:0];
                        if (prec_neg)
                        begin
                            m = (prec_acc > {32'd0, OUT_NEG_MAX})
                                ? {32'd0, OUT_NEG_MAX} : prec_acc;
                            res.precision = 32'd0 - m[31:0];
                        end
                        else
                        begin
                            m = (prec_acc > {32'd0, OUT_POS_MAX})
                                ? {32'd0, OUT_POS_MAX} : prec_acc;
                            res.precision = m[31:0];
                        end
                        res.no_precision = dot_missing;
                        res.length = length_sel;
                        res.conversion = conv_ok ? c : 8'h00;
                        res.consumed = conv_ok;
                        spec_stage = ST_FLAGS;
                        spec_flags = 5'b0;
                        spec_suppress = 1'b0;
                        width_acc = 64'd0;
                        prec_acc = 64'd0;
                        prec_neg = 1'b0;
                        prec_frozen = 1'b0;
                        dot_missing = 1'b0;
                        length_sel = LEN_NONE;
                        settled = 1'b1;
                        emitted = 1'b1;
                    end
                endcase
            end
            return emitted;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        begin
            if (got !== want)
            begin
                $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            format_char <= 8'h00;
            argument_value <= 32'sd0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                format_char <= pending_chars[0].ch;
                argument_value <= pending_chars[0].arg;
                pending_chars.delete(0);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                specs_checked++;
                if (expected_specs.size() == 0)
                begin
                    $display("%0t ns: result with no request pending, expected none, actual %h",
                             $time, conversion_char);
                    mismatches++;
                end
                else
                begin
                    oldest_spec = expected_specs.pop_front();
                    check_field("flag_minus", 32'(oldest_spec.minus), 32'(flag_minus));
                    check_field("flag_plus", 32'(oldest_spec.plus), 32'(flag_plus));
                    check_field("flag_space", 32'(oldest_spec.space), 32'(flag_space));
                    check_field("flag_alternate", 32'(oldest_spec.alternate),
                                32'(flag_alternate));
                    check_field("flag_zero_pad", 32'(oldest_spec.zero_pad),
                                32'(flag_zero_pad));
                    check_field("suppress_assign", 32'(oldest_spec.suppress),
                                32'(suppress_assign));
                    check_field("field_width", 32'(oldest_spec.width), 32'(field_width));
                    check_field("field_precision", oldest_spec.precision, field_precision);
                    check_field("precision_absent", 32'(oldest_spec.no_precision),
                                32'(precision_absent));
                    check_field("length_code", 32'(oldest_spec.length), 32'(length_code));
                    check_field("conversion_char", 32'(oldest_spec.conversion),
                                32'(conversion_char));
                    check_field("last_consumed", 32'(oldest_spec.consumed),
                                32'(last_consumed));
                end
            end
            if (in_valid && !in_stall)
            begin
                chars_accepted++;
                if (parse_spec_char(format_char, argument_value, parsed_spec))
                    expected_specs.push_back(parsed_spec);
            end
        end
    end

    task automatic push_char(input logic [7:0] c, input logic [31:0] arg);
        begin
            pending_chars.push_back({c, arg});
            chars_queued++;
        end
    endtask

    task automatic push_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                push_char(s[i], $urandom);
        end
    endtask

    task automatic push_digits(input int n);
        begin
            repeat (n) push_char(8'(CH_ZERO + $urandom_range(0, 9)), $urandom);
        end
    endtask

    function automatic logic [31:0] star_arg();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            4: return $urandom_range(0, 200);
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random_spec();
        int unsigned k;
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)), $urandom);
            end
            else
            begin
                repeat ($urandom_range(0, 3))
                begin
                    k = $urandom_range(0, 4);
                    push_char(FLAG_SET[k*8 +: 8], $urandom);
                end
                case ($urandom_range(0, 6))
                    0, 1: ;
                    2, 3: push_digits($urandom_range(1, 3));
                    4: push_digits($urandom_range(10, 12));
                    5: push_char(CH_STAR, star_arg());
                    default:
                    begin
                        push_digits($urandom_range(1, 2));
                        push_char(CH_STAR, star_arg());
                    end
                endcase
                if ($urandom_range(0, 99) < 60)
                begin
                    push_char(CH_DOT, $urandom);
                    case ($urandom_range(0, 6))
                        0: ;
                        1, 2: push_digits($urandom_range(1, 3));
                        3: push_digits($urandom_range(10, 12));
                        4:
                        begin
                            push_char(CH_MINUS, $urandom);
                            push_digits($urandom_range(0, 11));
                        end
                        5:
                        begin
                            push_digits($urandom_range(1, 2));
                            push_char(CH_MINUS, $urandom);
                            push_digits($urandom_range(0, 2));
                        end
                        default: push_char(CH_STAR, star_arg());
                    endcase
                end
                case ($urandom_range(0, 5))
                    0: push_char(CH_LOWER_H, $urandom);
                    1: push_char(CH_LOWER_L, $urandom);
                    2: push_char(CH_UPPER_L, $urandom);
                    default: ;
                endcase
                if ($urandom_range(0, 99) < 85)
                begin
                    k = $urandom_range(0, 15);
                    push_char((k == 15) ? CH_PERCENT : CONV_LETTERS[k*8 +: 8], $urandom);
                end
                else
                    push_char(8'($urandom_range(0, 255)), $urandom);
            end
        end
    endtask

    task automatic drain();
        begin
            @(negedge clk);
            while (pending_chars.size() != 0 || in_valid || expected_specs.size() != 0)
                @(negedge clk);
            repeat (3) @(negedge clk);
        end
    endtask

    task automatic write_scan_mode(input logic mode);
        begin
            @(posedge clk);
            cfg_write_enable <= 1'b1;
            cfg_write_data <= mode;
            @(posedge clk);
            cfg_write_enable <= 1'b0;
            scan_setting = mode;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("%");
        push_text("-+ #0i");
        push_char(CH_STAR, 32'h8000_0000);
        push_text("X");
        push_text("5*");
        push_char(8'h00, $urandom);
        push_text(".-3-4Lg");
        push_char(CH_DOT, $urandom);
        push_char(CH_STAR, 32'h8000_0000);
        push_text("h");
        push_char(8'hFF, $urandom);
        drain();
        write_scan_mode(1'b1);
        push_char(CH_STAR, 32'h7FFF_FFFF);
        push_text("lp");
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 57; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 57; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            write_scan_mode(phase % 2 == 1);
            for (int n = 0; n < 450; )
            begin
                n = n - int'(chars_queued);
                push_random_spec();
                n = n + int'(chars_queued);
            end
            // A closing conversion leaves the parser between specifiers before the next write.
            push_text("d");
            drain();
        end

        send_idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge clk);
        $display("Parsed %0d characters into %0d specifiers over both scan settings",
                 chars_accepted, specs_checked);
        $display("and four idling patterns; %0d field mismatches.", mismatches);
        if (mismatches == 0)
            $display("format_specifier_parser_unit verification clean");
        else
            $display("format_specifier_parser_unit verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("format_specifier_parser_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fsp_pkg.sv
rtl/format_specifier_parser_unit.sv
tb/format_specifier_parser_unit_test.sv
